@@ hdl/ckg_pkg.sv @@
// ----------------------------------------------------------------------------
// ckg_pkg
// Shared types, codes and helpers of the conic knapsack greedy fit block.
// ----------------------------------------------------------------------------
package ckg_pkg;

    localparam int SUM_W = 40;   // width of the running sums and the load
    localparam int IDXW  = 7;    // item index/count width at the largest item depth
    localparam int PROD_W = 72;  // 32 x 40 product

    localparam logic [39:0] LIM40 = 40'hFF_FFFF_FFFF;

    localparam logic [2:0] CFG_DALPHA     = 3'd0;
    localparam logic [2:0] CFG_CAPACITY   = 3'd1;
    localparam logic [2:0] CFG_ITEM_COUNT = 3'd2;
    localparam logic [2:0] CFG_TARGET     = 3'd3;
    localparam logic [2:0] CFG_TOLERANCE  = 3'd4;

    localparam logic [1:0] KIND_ITEM  = 2'd0;
    localparam logic [1:0] KIND_ROW   = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_STORE,
        OP_HOLD,
        OP_DOM_SET,
        OP_SEARCH_INIT,
        OP_SEED,
        OP_SQRT,
        OP_MUL_LOAD,
        OP_LOAD_FIN,
        OP_SEED_CHK,
        OP_GREEDY_INIT,
        OP_TRIAL,
        OP_EXCL_ONE,
        OP_DELTA,
        OP_MUL_P1,
        OP_P1_STORE,
        OP_MUL_P2,
        OP_CMP,
        OP_ADD,
        OP_ADD_FIN,
        OP_BEST,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [IDXW-1:0]   idx;
    } dp_cmd_t;

    typedef struct packed {
        logic              dom_hit;
        logic              seed_ok;
        logic              undecided;
        logic              fits;
        logic              found;
        logic              sqrt_done;
        logic              mul_done;
        logic [IDXW-1:0]   n_items;
        logic [IDXW-1:0]   cand;
    } dp_status_t;

    function automatic logic [39:0] sat_add40(input logic [39:0] a, input logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? LIM40 : s[39:0];
    endfunction

    function automatic logic [39:0] sat_add_val(input logic [39:0] a, input logic [31:0] b);
        logic [40:0] s;
        s = {a[39], a} + {{9{b[31]}}, b};
        if (s[40] != s[39]) begin
            return s[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end
        return s[39:0];
    endfunction

endpackage

@@ hdl/conic_knapsack_greedy_fit_top.sv @@
// ----------------------------------------------------------------------------
// conic_knapsack_greedy_fit_top
// Item loader and greedy fit search under a mean plus scaled deviation limit.
// ----------------------------------------------------------------------------
// Load beats (item values, conflict rows) are stored as they are accepted when idle.
// A start beat runs the search; s_tready stays low until the result is queued.
// The search runs a dominance scan over item pairs, then for each seed and each
// greedy round one pass over the undecided items. A load evaluation is a square
// root and a multiply, and a feasible candidate adds two 3-step ratio multiplies:
// O(n^3) evaluations in all.
// Synchronous active-low reset clears control state; item memories are unset.
module conic_knapsack_greedy_fit_top #(
    parameter int MAX_ITEMS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // item_index, objective, mean_weight,
                                   // variance_weight, conflict_row, zero pad
    input  logic [1:0]   s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,  // solution_mask, solution_value
    output logic [0:0]   m_tuser,  // accepted
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    import ckg_pkg::*;

    localparam logic [39:0] NEG_ONE = ~((40'd1 << FRAC_BITS) - 40'd1);

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [31:0] solution_mask;
    logic [39:0] solution_value;
    logic        accepted;

    ckg_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_kind  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ckg_dp #(.MAX_ITEMS(MAX_ITEMS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .in_kind            (s_tuser),
        .in_item_index      (s_tdata[4:0]),
        .in_objective       (s_tdata[36:5]),
        .in_mean_weight     (s_tdata[68:37]),
        .in_variance_weight (s_tdata[100:69]),
        .in_conflict_row    (s_tdata[132:101]),
        .solution_mask      (solution_mask),
        .solution_value     (solution_value),
        .accepted           (accepted)
    );

    assign m_tdata = {solution_value, solution_mask};
    assign m_tuser = accepted;

    a_result_after_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while input side was open");

    a_mask_within_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[31:0] >> status.n_items) == 32'd0))
        else $error("mask has items beyond the item count");

    a_empty_when_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[71:32] == NEG_ONE) |-> (m_tdata[31:0] == 32'd0))
        else $error("nonempty mask with no feasible seed");

endmodule

@@ hdl/ckg_sqrt.sv @@
// ----------------------------------------------------------------------------
// ckg_sqrt
// Iterative integer square root, rounded down, one result bit per cycle.
// ----------------------------------------------------------------------------
module ckg_sqrt #(
    parameter int W = 56
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [W-1:0]     radicand,
    output logic             done,
    output logic [W/2-1:0]   root
);
    localparam int RW   = W / 2;
    localparam int REMW = RW + 3;
    localparam int CNW  = $clog2(RW + 1);

    logic [W-1:0]    op_reg;
    logic [REMW-1:0] rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CNW-1:0]  cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;

    assign rem_sh = {rem_reg[REMW-3:0], op_reg[W-1:W-2]};
    assign trial  = REMW'({root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(RW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            op_reg <= op_reg << 2;
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ hdl/ckg_mul.sv @@
// ----------------------------------------------------------------------------
// ckg_mul
// Unsigned 32 x 40 multiplier, one 16-bit slice of the wide operand a cycle.
// ----------------------------------------------------------------------------
module ckg_mul
    import ckg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [31:0]         a,
    input  logic [39:0]         b,
    output logic                done,
    output logic [PROD_W-1:0]   prod
);
    localparam int CH  = 16;
    localparam int NCH = 3;

    logic [31:0]       a_reg;
    logic [NCH*CH-1:0] b_reg;
    logic [79:0]       acc_reg;
    logic [1:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [47:0]       part;

    assign part = a_reg * b_reg[NCH*CH-1 -: CH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 2'(NCH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // most significant slice first: shift the partial sum up, add the next slice
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= {8'd0, b};
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= (acc_reg << CH) + {32'd0, part};
            b_reg   <= b_reg << CH;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg[PROD_W-1:0];

endmodule

@@ hdl/ckg_dp.sv @@
// ----------------------------------------------------------------------------
// ckg_dp
// Datapath: item memories, configuration, sums, load evaluation and ratio test.
// ----------------------------------------------------------------------------
module ckg_dp #(
    parameter int MAX_ITEMS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ckg_pkg::dp_cmd_t       cmd,
    output ckg_pkg::dp_status_t    status,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_addr,
    input  logic [31:0]            cfg_wdata,
    input  logic [1:0]             in_kind,
    input  logic [4:0]             in_item_index,
    input  logic [31:0]            in_objective,
    input  logic [31:0]            in_mean_weight,
    input  logic [31:0]            in_variance_weight,
    input  logic [31:0]            in_conflict_row,
    output logic [31:0]            solution_mask,
    output logic [39:0]            solution_value,
    output logic                   accepted
);
    import ckg_pkg::*;

    localparam int IW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int SW0 = SUM_W + FRAC_BITS;
    localparam int SW  = SW0 + (SW0 % 2);
    localparam int RW  = SW / 2;
    localparam logic [39:0] NEG_ONE = ~((40'd1 << FRAC_BITS) - 40'd1);

    // configuration
    logic [31:0] dalpha_reg, capacity_reg, target_reg;
    logic [5:0]  item_count_reg;
    logic [15:0] tolerance_reg;

    // item store
    logic [95:0] vals_mem [MAX_ITEMS];
    logic [31:0] row_mem  [MAX_ITEMS];
    logic [95:0] rd_vals_reg;
    logic [31:0] rd_row_reg;

    logic [IW-1:0] idx;
    logic [CW-1:0] n_items;
    logic [31:0]   rd_obj, rd_mean, rd_var;

    logic [31:0] hold_obj_reg, hold_mean_reg, hold_var_reg;
    logic [MAX_ITEMS-1:0] dom_reg, packed_reg, excl_reg;
    logic [MAX_ITEMS-1:0] row_mask, packed_add, excl_add;
    logic [31:0] pend_row_reg;

    logic [39:0] sum_mean_reg, sum_var_reg, cur_load_reg, cur_val_reg;
    logic [39:0] best_val_reg;
    logic [MAX_ITEMS-1:0] best_mask_reg;
    logic [39:0] trial_mean_reg, trial_var_reg, load_reg, d_reg, bd_reg;
    logic [31:0] bo_reg;
    logic [IW-1:0] cand_reg;
    logic          found_reg;
    logic signed [72:0] p1_reg;

    logic [31:0] out_mask_reg;
    logic [39:0] out_val_reg;
    logic        out_acc_reg;

    // arithmetic units
    logic              sqrt_start, sqrt_done;
    logic [RW-1:0]     sqrt_root;
    logic              mul_start, mul_done;
    logic [31:0]       mul_a;
    logic [39:0]       mul_b;
    logic [PROD_W-1:0] mul_prod;

    logic [PROD_W-1:0]  scaled;
    logic [39:0]        load_calc;
    logic signed [72:0] p_signed;
    logic               better, fits, dom_hit, seed_ok;
    logic [31:0]        hold_mag, bo_mag;
    logic signed [40:0] thr;

    assign idx     = cmd.idx[IW-1:0];
    assign n_items = (int'(item_count_reg) > MAX_ITEMS) ? CW'(MAX_ITEMS) : CW'(item_count_reg);
    assign rd_obj  = rd_vals_reg[31:0];
    assign rd_mean = rd_vals_reg[63:32];
    assign rd_var  = rd_vals_reg[95:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dalpha_reg     <= '0;
            capacity_reg   <= '0;
            item_count_reg <= 6'd1;
            target_reg     <= '0;
            tolerance_reg  <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DALPHA:     dalpha_reg     <= cfg_wdata;
                CFG_CAPACITY:   capacity_reg   <= cfg_wdata;
                CFG_ITEM_COUNT: item_count_reg <= cfg_wdata[5:0];
                CFG_TARGET:     target_reg     <= cfg_wdata;
                CFG_TOLERANCE:  tolerance_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // item memories: one write, one registered read a cycle
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_STORE && 32'(in_item_index) < MAX_ITEMS) begin
            if (in_kind == KIND_ITEM) begin
                vals_mem[IW'(in_item_index)] <= {in_variance_weight, in_mean_weight, in_objective};
            end
            if (in_kind == KIND_ROW) begin
                row_mem[IW'(in_item_index)] <= in_conflict_row;
            end
        end
        rd_vals_reg <= vals_mem[idx];
        rd_row_reg  <= row_mem[idx];
    end

    always_comb begin
        for (int k = 0; k < MAX_ITEMS; k++) begin
            row_mask[k] = (k < 32) && (CW'(k) < n_items) && pend_row_reg[5'(k)];
        end
    end

    always_comb begin
        excl_add   = excl_reg | row_mask;
        packed_add = packed_reg & ~row_mask;
        excl_add[cand_reg]   = 1'b0;
        packed_add[cand_reg] = 1'b1;
    end

    assign dom_hit = (hold_mean_reg >= rd_mean) && (hold_var_reg >= rd_var)
                     && ($signed(hold_obj_reg) <= $signed(rd_obj));
    assign seed_ok = ($signed({rd_obj[31], rd_obj}) >= $signed({17'd0, tolerance_reg}))
                     && !dom_reg[idx];
    assign fits    = load_reg <= {8'd0, capacity_reg};

    assign scaled    = mul_prod >> FRAC_BITS;
    assign load_calc = (|scaled[PROD_W-1:40]) ? LIM40 : sat_add40(trial_mean_reg, scaled[39:0]);

    assign hold_mag = hold_obj_reg[31] ? (~hold_obj_reg + 32'd1) : hold_obj_reg;
    assign bo_mag   = bo_reg[31] ? (~bo_reg + 32'd1) : bo_reg;
    assign p_signed = bo_reg[31] ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
    assign better   = p1_reg > p_signed;

    assign sqrt_start = (cmd.op == OP_SQRT);
    assign mul_start  = (cmd.op == OP_MUL_LOAD) || (cmd.op == OP_MUL_P1) || (cmd.op == OP_MUL_P2);

    always_comb begin
        case (cmd.op)
            OP_MUL_LOAD: begin
                mul_a = dalpha_reg;
                mul_b = 40'(sqrt_root);
            end
            OP_MUL_P1: begin
                mul_a = hold_mag;
                mul_b = bd_reg;
            end
            default: begin
                mul_a = bo_mag;
                mul_b = d_reg;
            end
        endcase
    end

    ckg_sqrt #(.W(SW)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (SW'({trial_var_reg, FRAC_BITS'(0)})),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    ckg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dom_reg       <= '0;
            packed_reg    <= '0;
            excl_reg      <= '0;
            found_reg     <= 1'b0;
            best_val_reg  <= NEG_ONE;
            best_mask_reg <= '0;
            sum_mean_reg  <= '0;
            sum_var_reg   <= '0;
            cur_load_reg  <= '0;
            cur_val_reg   <= '0;
        end else begin
            case (cmd.op)
                OP_HOLD: begin
                    hold_obj_reg  <= rd_obj;
                    hold_mean_reg <= rd_mean;
                    hold_var_reg  <= rd_var;
                    dom_reg[idx]  <= 1'b0;
                end
                OP_DOM_SET: dom_reg[idx] <= 1'b1;
                OP_SEARCH_INIT: begin
                    best_val_reg  <= NEG_ONE;
                    best_mask_reg <= '0;
                end
                OP_SEED: begin
                    packed_reg      <= MAX_ITEMS'(1) << idx;
                    excl_reg        <= '0;
                    sum_mean_reg    <= {8'd0, rd_mean};
                    sum_var_reg     <= {8'd0, rd_var};
                    trial_mean_reg  <= {8'd0, rd_mean};
                    trial_var_reg   <= {8'd0, rd_var};
                    cur_val_reg     <= {{8{rd_obj[31]}}, rd_obj};
                    pend_row_reg    <= rd_row_reg;
                end
                OP_LOAD_FIN: load_reg <= load_calc;
                OP_SEED_CHK: begin
                    cur_load_reg <= load_reg;
                    if (fits) begin
                        excl_reg   <= excl_reg | row_mask;
                        packed_reg <= packed_reg & ~row_mask;
                    end
                end
                OP_GREEDY_INIT: begin
                    bo_reg    <= '1;
                    bd_reg    <= 40'd1;
                    found_reg <= 1'b0;
                end
                OP_TRIAL: begin
                    hold_obj_reg   <= rd_obj;
                    trial_mean_reg <= sat_add40(sum_mean_reg, {8'd0, rd_mean});
                    trial_var_reg  <= sat_add40(sum_var_reg, {8'd0, rd_var});
                end
                OP_EXCL_ONE: excl_reg[idx] <= 1'b1;
                OP_DELTA: d_reg <= (load_reg > cur_load_reg) ? load_reg - cur_load_reg : 40'd0;
                OP_P1_STORE: begin
                    p1_reg <= hold_obj_reg[31] ? -$signed({1'b0, mul_prod})
                                               : $signed({1'b0, mul_prod});
                end
                OP_CMP: begin
                    if (better) begin
                        bo_reg    <= hold_obj_reg;
                        bd_reg    <= d_reg;
                        cand_reg  <= idx;
                        found_reg <= 1'b1;
                    end
                end
                OP_ADD: begin
                    sum_mean_reg   <= sat_add40(sum_mean_reg, {8'd0, rd_mean});
                    sum_var_reg    <= sat_add40(sum_var_reg, {8'd0, rd_var});
                    trial_mean_reg <= sat_add40(sum_mean_reg, {8'd0, rd_mean});
                    trial_var_reg  <= sat_add40(sum_var_reg, {8'd0, rd_var});
                    cur_val_reg    <= sat_add_val(cur_val_reg, rd_obj);
                    pend_row_reg   <= rd_row_reg;
                end
                OP_ADD_FIN: begin
                    cur_load_reg <= load_reg;
                    excl_reg     <= excl_add;
                    packed_reg   <= packed_add;
                end
                OP_BEST: begin
                    if ($signed(cur_val_reg) > $signed(best_val_reg)) begin
                        best_val_reg  <= cur_val_reg;
                        best_mask_reg <= packed_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign thr = $signed({{9{target_reg[31]}}, target_reg}) + $signed({25'd0, tolerance_reg});

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            out_mask_reg <= 32'(best_mask_reg);
            out_val_reg  <= best_val_reg;
            out_acc_reg  <= $signed({best_val_reg[39], best_val_reg}) > thr;
        end
    end

    assign solution_mask  = out_mask_reg;
    assign solution_value = out_val_reg;
    assign accepted       = out_acc_reg;

    always_comb begin
        status           = '0;
        status.dom_hit   = dom_hit;
        status.seed_ok   = seed_ok;
        status.undecided = !packed_reg[idx] && !excl_reg[idx];
        status.fits      = fits;
        status.found     = found_reg;
        status.sqrt_done = sqrt_done;
        status.mul_done  = mul_done;
        status.n_items   = IDXW'(n_items);
        status.cand      = IDXW'(cand_reg);
    end

endmodule

@@ hdl/ckg_ctrl.sv @@
// ----------------------------------------------------------------------------
// ckg_ctrl
// Search sequencer: dominance scan, seed loop, greedy rounds, result handoff.
// ----------------------------------------------------------------------------
module ckg_ctrl #(
    parameter int MAX_ITEMS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             in_kind,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output ckg_pkg::dp_cmd_t       cmd,
    input  ckg_pkg::dp_status_t    status
);
    import ckg_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_D_I, ST_D_IW, ST_D_J, ST_D_JW, ST_S_F, ST_S_FW,
        ST_E_SQ, ST_E_SQW, ST_E_MU, ST_E_MUW, ST_E_FIN, ST_S_CHK,
        ST_G_INIT, ST_G_I, ST_G_IW, ST_G_CHK, ST_G_M1, ST_G_M1W,
        ST_G_M2, ST_G_M2W, ST_G_CMP, ST_G_END, ST_G_AW, ST_G_AFIN,
        ST_S_BEST, ST_DONE
    } state_t;

    typedef enum logic [1:0] { RET_SEED, RET_CAND, RET_ADD } ret_t;

    state_t        state_reg, state_next;
    ret_t          ret_reg, ret_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, fix_reg, fix_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [CW-1:0] n_items;

    assign n_items = status.n_items[CW-1:0];

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        fix_next      = fix_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = OP_NONE;
        cmd.idx       = IDXW'(i_reg);
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_STORE;
                    if (in_kind == KIND_START) begin
                        i_next     = '0;
                        state_next = ST_D_I;
                    end
                end
            end
            ST_D_I: begin
                if (i_reg == n_items) begin
                    cmd.op     = OP_SEARCH_INIT;
                    fix_next   = '0;
                    state_next = ST_S_F;
                end else begin
                    state_next = ST_D_IW;
                end
            end
            ST_D_IW: begin
                cmd.op     = OP_HOLD;
                j_next     = i_reg + 1'b1;
                state_next = ST_D_J;
            end
            ST_D_J: begin
                cmd.idx = IDXW'(j_reg);
                if (j_reg >= n_items) begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_D_I;
                end else begin
                    state_next = ST_D_JW;
                end
            end
            ST_D_JW: begin
                if (status.dom_hit) begin
                    cmd.op     = OP_DOM_SET;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_D_I;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_D_J;
                end
            end
            ST_S_F: begin
                cmd.idx = IDXW'(fix_reg);
                state_next = (fix_reg == n_items) ? ST_DONE : ST_S_FW;
            end
            ST_S_FW: begin
                cmd.idx = IDXW'(fix_reg);
                if (status.seed_ok) begin
                    cmd.op     = OP_SEED;
                    ret_next   = RET_SEED;
                    state_next = ST_E_SQ;
                end else begin
                    fix_next   = fix_reg + 1'b1;
                    state_next = ST_S_F;
                end
            end
            ST_E_SQ: begin
                cmd.op     = OP_SQRT;
                state_next = ST_E_SQW;
            end
            ST_E_SQW: begin
                if (status.sqrt_done) state_next = ST_E_MU;
            end
            ST_E_MU: begin
                cmd.op     = OP_MUL_LOAD;
                state_next = ST_E_MUW;
            end
            ST_E_MUW: begin
                if (status.mul_done) state_next = ST_E_FIN;
            end
            ST_E_FIN: begin
                cmd.op = OP_LOAD_FIN;
                case (ret_reg)
                    RET_SEED: state_next = ST_S_CHK;
                    RET_CAND: state_next = ST_G_CHK;
                    default:  state_next = ST_G_AFIN;
                endcase
            end
            ST_S_CHK: begin
                cmd.op = OP_SEED_CHK;
                if (status.fits) begin
                    state_next = ST_G_INIT;
                end else begin
                    fix_next   = fix_reg + 1'b1;
                    state_next = ST_S_F;
                end
            end
            ST_G_INIT: begin
                cmd.op     = OP_GREEDY_INIT;
                i_next     = '0;
                state_next = ST_G_I;
            end
            ST_G_I: begin
                if (i_reg == n_items) begin
                    state_next = ST_G_END;
                end else if (status.undecided) begin
                    state_next = ST_G_IW;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_G_IW: begin
                cmd.op     = OP_TRIAL;
                ret_next   = RET_CAND;
                state_next = ST_E_SQ;
            end
            ST_G_CHK: begin
                if (status.fits) begin
                    cmd.op     = OP_DELTA;
                    state_next = ST_G_M1;
                end else begin
                    // infeasible now, infeasible for the rest of this seed
                    cmd.op     = OP_EXCL_ONE;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_G_I;
                end
            end
            ST_G_M1: begin
                cmd.op     = OP_MUL_P1;
                state_next = ST_G_M1W;
            end
            ST_G_M1W: begin
                if (status.mul_done) begin
                    cmd.op     = OP_P1_STORE;
                    state_next = ST_G_M2;
                end
            end
            ST_G_M2: begin
                cmd.op     = OP_MUL_P2;
                state_next = ST_G_M2W;
            end
            ST_G_M2W: begin
                if (status.mul_done) state_next = ST_G_CMP;
            end
            ST_G_CMP: begin
                cmd.op     = OP_CMP;
                i_next     = i_reg + 1'b1;
                state_next = ST_G_I;
            end
            ST_G_END: begin
                cmd.idx    = status.cand;
                state_next = status.found ? ST_G_AW : ST_S_BEST;
            end
            ST_G_AW: begin
                cmd.idx    = status.cand;
                cmd.op     = OP_ADD;
                ret_next   = RET_ADD;
                state_next = ST_E_SQ;
            end
            ST_G_AFIN: begin
                cmd.op     = OP_ADD_FIN;
                state_next = ST_G_INIT;
            end
            ST_S_BEST: begin
                cmd.op     = OP_BEST;
                fix_next   = fix_reg + 1'b1;
                state_next = ST_S_F;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = OP_EMIT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= RET_SEED;
            i_reg        <= '0;
            j_reg        <= '0;
            fix_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            fix_reg      <= fix_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

@@ verif/conic_knapsack_greedy_fit_top_tb.sv @@
// ----------------------------------------------------------------------------
// conic_knapsack_greedy_fit_top_tb
// Loads item sets and conflict rows, starts greedy fit searches under several
// register settings, and checks every solution beat against a local model.
// ----------------------------------------------------------------------------
module conic_knapsack_greedy_fit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ckg_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam longint MINUS_ONE = -(64'sd1 <<< 16);
    localparam longint VMAX = 64'sh7F_FFFF_FFFF;
    localparam longint VMIN = -VMAX - 1;

    typedef enum logic [1:0] {ST_OPEN, ST_OUT, ST_IN} pick_t;

    typedef struct packed {
        logic [31:0] mask;
        logic [39:0] value;
        logic        accepted;
    } fit_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    conic_knapsack_greedy_fit_top dut (.*);

    always #10 aclk = ~aclk;

    // model copy of registers and item memories
    logic [31:0] r_dalpha = 0, r_capacity = 0, r_target = 0;
    logic [5:0]  r_count = 1;
    logic [15:0] r_tol = 1;
    logic [31:0] m_obj [32];
    logic [31:0] m_mean [32];
    logic [31:0] m_var [32];
    logic [31:0] m_row [32];

    fit_t pending_fit[$];
    int   errors = 0;
    int   sent = 0;
    bit   quiet = 0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s = a + b;
        return (s > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : s;
    endfunction

    function automatic longint unsigned load_of(longint unsigned mn, longint unsigned vr);
        longint unsigned r = root_floor((vr & 64'hFF_FFFF_FFFF) << 16);
        return add_sat(mn, (64'(r_dalpha) * r) >> 16);
    endfunction

    function automatic fit_t predict_fit();
        fit_t res;
        int n, fix, i, j, cand;
        bit dom [32];
        pick_t st [32];
        longint unsigned sm, sv, cl, l, d, bd;
        longint cv, best, o, oi, bo;
        logic [31:0] bmask;
        logic signed [79:0] lhs, rhs;
        bit found;
        n = (r_count > 32) ? 32 : int'(r_count);
        for (i = 0; i < n; i++) begin
            dom[i] = 0;
            for (j = i + 1; j < n; j++)
                if (m_mean[i] >= m_mean[j] && m_var[i] >= m_var[j] &&
                    $signed(m_obj[i]) <= $signed(m_obj[j])) begin
                    dom[i] = 1;
                    break;
                end
        end
        best = MINUS_ONE;
        bmask = 0;
        for (fix = 0; fix < n; fix++) begin
            o = longint'($signed(m_obj[fix]));
            if (o < longint'(r_tol) || dom[fix]) continue;
            for (i = 0; i < 32; i++) st[i] = ST_OPEN;
            sm = 64'(m_mean[fix]);
            sv = 64'(m_var[fix]);
            cv = o;
            st[fix] = ST_IN;
            cl = load_of(sm, sv);
            if (cl > 64'(r_capacity)) continue;
            for (j = 0; j < n; j++) if (m_row[fix][j]) st[j] = ST_OUT;
            while (1) begin
                bo = -1;
                bd = 1;
                found = 0;
                cand = 0;
                for (i = 0; i < n; i++) begin
                    if (st[i] != ST_OPEN) continue;
                    l = load_of(add_sat(sm, 64'(m_mean[i])), add_sat(sv, 64'(m_var[i])));
                    if (l > 64'(r_capacity)) begin
                        st[i] = ST_OUT;
                        continue;
                    end
                    d = (l > cl) ? l - cl : 0;
                    oi = longint'($signed(m_obj[i]));
                    lhs = 80'(oi);
                    rhs = 80'(bo);
                    lhs = lhs * $signed({16'd0, bd});
                    rhs = rhs * $signed({16'd0, d});
                    if (lhs > rhs) begin
                        bo = oi;
                        bd = d;
                        cand = i;
                        found = 1;
                    end
                end
                if (!found) break;
                sm = add_sat(sm, 64'(m_mean[cand]));
                sv = add_sat(sv, 64'(m_var[cand]));
                cv += longint'($signed(m_obj[cand]));
                if (cv > VMAX) cv = VMAX;
                if (cv < VMIN) cv = VMIN;
                cl = load_of(sm, sv);
                for (j = 0; j < n; j++) if (m_row[cand][j]) st[j] = ST_OUT;
                st[cand] = ST_IN;
            end
            if (cv > best) begin
                best = cv;
                bmask = 0;
                for (i = 0; i < n; i++) if (st[i] == ST_IN) bmask[i] = 1'b1;
            end
        end
        res.mask = bmask;
        res.value = best[39:0];
        res.accepted = best > longint'($signed(r_target)) + longint'(r_tol);
        return res;
    endfunction

    task automatic report(string what, logic [39:0] got, logic [39:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        fit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_fit.size() == 0) begin
                report("unexpected beat", m_tdata[39:0], 0);
            end else begin
                want = pending_fit.pop_front();
                if (m_tdata[31:0] != want.mask) report("mask", 40'(m_tdata[31:0]), 40'(want.mask));
                if (m_tdata[71:32] != want.value) report("value", m_tdata[71:32], want.value);
                if (m_tuser[0] != want.accepted)
                    report("accepted", 40'(m_tuser[0]), 40'(want.accepted));
            end
        end
    end

    // result-side backpressure
    initial begin
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send(logic [1:0] kind, logic [4:0] idx, logic [31:0] obj,
                        logic [31:0] mn, logic [31:0] vr, logic [31:0] row);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {3'd0, row, vr, mn, obj, idx};
        do @(posedge aclk); while (!s_tready);
        sent++;
        case (kind)
            KIND_ITEM: begin
                m_obj[idx] = obj;
                m_mean[idx] = mn;
                m_var[idx] = vr;
            end
            KIND_ROW: m_row[idx] = row;
            KIND_START: pending_fit.insert(pending_fit.size(), predict_fit());
            default: ;
        endcase
    endtask

    task automatic load_item(int idx, logic [31:0] obj, logic [31:0] mn, logic [31:0] vr);
        send(KIND_ITEM, 5'(idx), obj, mn, vr, $urandom);
    endtask

    task automatic load_row(int idx, logic [31:0] row);
        send(KIND_ROW, 5'(idx), $urandom, $urandom, $urandom, row);
    endtask

    task automatic start_fit();
        send(KIND_START, 5'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    // drop valid, drain results, then give the search time to wind down
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_fit.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            CFG_DALPHA: r_dalpha = data;
            CFG_CAPACITY: r_capacity = data;
            CFG_ITEM_COUNT: r_count = data[5:0];
            CFG_TARGET: r_target = data;
            CFG_TOLERANCE: r_tol = data[15:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [31:0] da, logic [31:0] cap, logic [5:0] cnt,
                           logic [31:0] tgt, logic [15:0] tol);
        settle();
        cfg_write(CFG_DALPHA, da);
        cfg_write(CFG_CAPACITY, cap);
        cfg_write(CFG_ITEM_COUNT, 32'(cnt));
        cfg_write(CFG_TARGET, tgt);
        cfg_write(CFG_TOLERANCE, 32'(tol));
    endtask

    function automatic logic [31:0] rand_obj();
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return $urandom_range(0, 12 << 16) - (2 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 0;
            default: return $urandom_range(0, 4 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rand_row();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 0;
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    // reset defaults: capacity zero, so the lone item cannot fit
    task automatic test_reset_defaults();
        load_item(0, 32'h0001_0000, 32'h0000_8000, 0);
        load_row(0, 0);
        start_fit();
        settle();
        cfg_write(CFG_CAPACITY, 32'h0001_0000);
        start_fit();
    endtask

    task automatic test_extremes();
        cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 32'h8000_0000, 0);
        load_item(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        load_item(1, 32'h8000_0000, 0, 0);
        load_item(2, 0, 0, 0);
        load_row(0, 0);
        load_row(1, 0);
        load_row(2, 0);
        start_fit();
        cfg_all(0, 32'hFFFF_FFFF, 3, 32'h7FFF_FFFF, 16'hFFFF);
        start_fit();
    endtask

    // own-bit conflict, row bits above the count, dominated seed
    task automatic test_conflicts();
        cfg_all(32'h0001_0000, 32'h0010_0000, 3, 0, 1);
        load_item(0, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000);
        load_item(1, 32'h0003_0000, 32'h0001_0000, 32'h0000_4000);
        load_item(2, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000);
        load_row(0, 32'h0000_0003);
        load_row(1, 32'hFFFF_FFF8);
        load_row(2, 32'h0000_0004);
        start_fit();
        send(KIND_SPARE, 0, $urandom, $urandom, $urandom, $urandom);
        start_fit();
    endtask

    task automatic test_counts();
        int i;
        cfg_all(32'h0001_0000, 32'h0004_0000, 0, 32'hFFFF_0000, 0);
        start_fit();
        for (i = 0; i < 32; i++) begin
            load_item(i, rand_obj(), rand_weight(), rand_weight());
            load_row(i, rand_row());
        end
        cfg_all($urandom, 0, 32, $urandom, 16'($urandom));
        start_fit();
        cfg_all(32'h0000_4000, 32'h0000_0100, 63, 0, 1);
        start_fit();
    endtask

    task automatic random_phase();
        int n, i, k;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        if ($urandom_range(0, 2) == 0 || n != r_count) begin
            case ($urandom_range(0, 4))
                0: cfg_all($urandom, $urandom, 6'(n), $urandom, 16'($urandom));
                1: cfg_all(0, 32'hFFFF_FFFF, 6'(n), 32'h8000_0000, 0);
                default: cfg_all($urandom_range(0, 2 << 16), $urandom_range(0, 16 << 16), 6'(n),
                                 $urandom_range(0, 8 << 16) - (2 << 16),
                                 16'($urandom_range(0, 65535)));
            endcase
        end
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) load_item(i, rand_obj(), rand_weight(), rand_weight());
            if ($urandom_range(0, 2) == 0) load_row(i, rand_row());
        end
        for (k = $urandom_range(0, 2); k > 0; k--) begin
            case ($urandom_range(0, 2))
                0: send(KIND_SPARE, 5'($urandom), $urandom, $urandom, $urandom, $urandom);
                1: load_item($urandom_range(0, 31), rand_obj(), rand_weight(), rand_weight());
                default: load_row($urandom_range(0, 31), rand_row());
            endcase
        end
        start_fit();
    endtask

    task automatic test_random();
        while (sent < 1800) random_phase();
    endtask

    task automatic test_quiet_tail();
        settle();
        quiet = 1;
        while (sent < 2000) random_phase();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_extremes();
        test_conflicts();
        test_counts();
        test_random();
        test_quiet_tail();
        settle();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2s;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ conic_knapsack_greedy_fit_top.f @@
hdl/ckg_pkg.sv
hdl/ckg_sqrt.sv
hdl/ckg_mul.sv
hdl/ckg_dp.sv
hdl/ckg_ctrl.sv
hdl/conic_knapsack_greedy_fit_top.sv
verif/conic_knapsack_greedy_fit_top_tb.sv
